[rtl/core/sbd_pkg.sv]
// Shared types and constants for the six-bit text code decoder.
package sbd_pkg;

  // Depth of the record queue between the front and back parts.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Six-bit code that announces a seven-bit literal.
  localparam logic [5:0] CODE_ESCAPE = 6'd32;
  // Literals with a special meaning after an escape.
  localparam logic [6:0] LIT_CASE_TOGGLE = 7'd27;
  localparam logic [6:0] LIT_END = 7'd48;

  // Decoded results of one byte: up to two characters.
  typedef struct packed {
    logic [6:0] char0;
    logic       eos0;
    logic [6:0] char1;
    logic       eos1;
    logic       two;
  } sbd_rec_t;

endpackage

[rtl/core/sbd_front.sv]
// Front part: takes packed bytes, unpacks codes and decodes them into records.
module sbd_front import sbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       q_ready,
  output logic       q_push,
  output sbd_rec_t   q_wdata
);

  logic [6:0] pend_bits_r, pend_bits_nxt;
  logic [2:0] pend_cnt_r, pend_cnt_nxt;
  logic       esc_r, esc_nxt;
  logic       lower_r, lower_nxt;
  logic       ended_r, ended_nxt;
  logic [1:0] n_res;
  logic [6:0] res_char [2];
  logic       res_eos  [2];
  logic       accept;

  function automatic logic [6:0] map_code(logic [5:0] code, logic lower);
    logic [6:0] ch;
    if (code == 6'd0) begin
      ch = 7'd32;
    end else if (code inside {[6'd1:6'd7]}) begin
      ch = 7'(code) + 7'd8;
    end else if (code inside {[6'd8:6'd61]}) begin
      if (lower && (code inside {[6'd33:6'd58]})) begin
        ch = 7'(code) + 7'd64;
      end else begin
        ch = 7'(code) + 7'd32;
      end
    end else if (code == 6'd62) begin
      ch = 7'd27;
    end else begin
      ch = 7'd127;
    end
    return ch;
  endfunction

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  // A byte yields at most two codes, so the decode is two unrolled steps.
  always_comb begin
    logic [14:0] acc;
    logic [14:0] shifted;
    logic [14:0] keep_mask;
    logic [3:0]  cnt;
    logic [3:0]  need;
    logic        stop;
    esc_nxt   = esc_r;
    lower_nxt = lower_r;
    ended_nxt = ended_r;
    n_res     = 2'd0;
    stop      = 1'b0;
    shifted   = '0;
    for (int i = 0; i < 2; i++) begin
      res_char[i] = '0;
      res_eos[i]  = 1'b0;
    end
    acc = {pend_bits_r & 7'((8'd1 << pend_cnt_r) - 8'd1), in_data_byte};
    cnt = {1'b0, pend_cnt_r} + 4'd8;
    for (int i = 0; i < 2; i++) begin
      need = esc_nxt ? 4'd7 : 4'd6;
      if (!stop && (cnt >= need)) begin
        shifted = acc >> (cnt - need);
        cnt     = cnt - need;
        if (esc_nxt) begin
          esc_nxt = 1'b0;
          if (shifted[6:0] == LIT_END) begin
            res_char[n_res[0]] = '0;
            res_eos[n_res[0]]  = 1'b1;
            n_res     = n_res + 2'd1;
            ended_nxt = 1'b1;
            cnt       = 4'd0;
            stop      = 1'b1;
          end else if (shifted[6:0] == LIT_CASE_TOGGLE) begin
            lower_nxt = !lower_nxt;
          end else begin
            res_char[n_res[0]] = shifted[6:0];
            n_res = n_res + 2'd1;
          end
        end else if (shifted[5:0] == CODE_ESCAPE) begin
          esc_nxt = 1'b1;
        end else begin
          res_char[n_res[0]] = map_code(shifted[5:0], lower_nxt);
          n_res = n_res + 2'd1;
        end
      end else begin
        stop = 1'b1;
      end
    end
    keep_mask    = (15'd1 << cnt) - 15'd1;
    pend_cnt_nxt = cnt[2:0];
    pend_bits_nxt = acc[6:0] & keep_mask[6:0];
  end

  assign q_push         = accept && !ended_r && (n_res != 2'd0);
  assign q_wdata.char0  = res_char[0];
  assign q_wdata.eos0   = res_eos[0];
  assign q_wdata.char1  = res_char[1];
  assign q_wdata.eos1   = res_eos[1];
  assign q_wdata.two    = n_res[1];

  // Once the end marker is seen, words are taken and dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      esc_r       <= 1'b0;
      lower_r     <= 1'b0;
      ended_r     <= 1'b0;
    end else if (accept && !ended_r) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      esc_r       <= esc_nxt;
      lower_r     <= lower_nxt;
      ended_r     <= ended_nxt;
    end
  end

endmodule

[rtl/core/sbd_queue.sv]
// Short record queue between the front and back parts.
module sbd_queue import sbd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  sbd_rec_t wdata,
  output logic     push_ready,
  input  logic     pop,
  output logic     pop_valid,
  output sbd_rec_t rdata
);

  sbd_rec_t          entries_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign rdata      = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/core/sbd_back.sv]
// Back part: output register that sends the results of each record in turn.
module sbd_back import sbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  sbd_rec_t   q_rdata,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_end_of_stream,
  output logic       out_last
);

  sbd_rec_t cur_r;
  logic     cur_valid_r, cur_valid_nxt;
  logic     sel_r, sel_nxt;
  logic     finish;

  assign finish = cur_valid_r && out_ready && (!cur_r.two || sel_r);
  assign q_pop  = q_valid && (!cur_valid_r || finish);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    sel_nxt       = sel_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      sel_nxt       = 1'b0;
    end else if (finish) begin
      cur_valid_nxt = 1'b0;
      sel_nxt       = 1'b0;
    end else if (cur_valid_r && out_ready) begin
      sel_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rdata;
    end
  end

  assign out_valid         = cur_valid_r;
  assign out_char          = sel_r ? cur_r.char1 : cur_r.char0;
  assign out_end_of_stream = sel_r ? cur_r.eos1 : cur_r.eos0;
  assign out_last          = !cur_r.two || sel_r;

endmodule

[rtl/core/six_bit_text_code_decoder.sv]
// Top level of the six-bit text code decoder: front, record queue and back.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid / in_ready  in_data_byte[7:0]
//   out_      output     out_valid/out_ready  out_char[6:0], out_end_of_stream, out_last
//
// Each input word is decoded in the cycle it is accepted; its one or two results
// are queued as one record, a word with no result queues nothing, and the
// results leave the output register one per cycle while out_ready is high.
// The output side sets the sustained rate, so a word that yields two characters
// occupies the output for both of its results, one after the other.
// A result is registered in a queue entry and then in the output register.
// Reset (synchronous, active low) empties the queue and the output register and
// clears the pending bits, escape mode, case flag and end-of-stream flag.
// Input and output stall independently; in_ready drops only when the queue is full.
// After the end marker, input words are still accepted but produce nothing.
module six_bit_text_code_decoder import sbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_end_of_stream,
  output logic       out_last
);

  // Queue handshake between the front and back parts.
  logic     q_push;
  logic     q_push_ready;
  sbd_rec_t q_wdata;
  logic     q_pop;
  logic     q_pop_valid;
  sbd_rec_t q_rdata;

  // The front decodes up to two codes from the pending bits plus the new word.
  sbd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .q_ready      (q_push_ready),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  // The queue decouples decoding from output back-pressure.
  sbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wdata      (q_wdata),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_valid  (q_pop_valid),
    .rdata      (q_rdata)
  );

  // The back part walks each record and marks its final result as last.
  sbd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_pop_valid),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char          (out_char),
    .out_end_of_stream (out_end_of_stream),
    .out_last          (out_last)
  );

`ifndef SYNTHESIS
  // The end result is always the final one of its word and carries a zero.
  a_eos_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_stream) |-> (out_last && (out_char == 7'd0)))
    else $error("end-of-stream result is not last or has nonzero char");

  // Nothing follows the end result once it is taken.
  a_nothing_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_end_of_stream) |=> !out_valid)
    else $error("result after end of stream");

  // The end marker stops decoding, so it never precedes a second result.
  a_eos_not_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_wdata.two) |-> !q_wdata.eos0)
    else $error("record continues past the end marker");
`endif

endmodule

[tb/sv/six_bit_text_code_decoder_tb.sv]
// Self-checking testbench for the six-bit text code decoder.
module six_bit_text_code_decoder_tb;
  import sbd_pkg::*;

  // Characters that the code mapping produces outside the plain offsets.
  localparam logic [6:0] CHAR_SPACE = 7'd32;
  localparam logic [6:0] CHAR_ESC = 7'd27;
  localparam logic [6:0] CHAR_DEL = 7'd127;
  // Six-bit codes with a fixed character of their own.
  localparam logic [5:0] CODE_SPACE = 6'd0;
  localparam logic [5:0] CODE_TO_ESC = 6'd62;

  // Stimulus sizes and the points where the run changes its pace.
  localparam int TOTAL_WORDS = 700;
  localparam int HOLD_START = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int CALM_FIRST = 500;
  localparam int CALM_LAST = 620;
  localparam int MID_DRAIN = 450;
  localparam int MAX_REPORTS = 10;

  // Decoder state as the block keeps it between words.
  typedef struct packed {
    logic [6:0] pbits;
    logic [2:0] pcount;
    logic       esc;
    logic       lower;
    logic       ended;
  } dec_state_t;

  // Outcome of decoding one word: the new state and up to two characters.
  typedef struct packed {
    dec_state_t      st;
    logic [1:0]      n;
    logic [1:0][6:0] ch;
    logic [1:0]      eos;
  } dec_step_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       eos;
    logic       last;
  } char_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_char;
  logic       out_end_of_stream;
  logic       out_last;

  // Words waiting to be sent, and the characters the block still owes us.
  logic [7:0]   byte_plan[$];
  char_result_t expected_chars[$];
  // Bits of well-formed code sequences, MSB first, before they are packed.
  bit           code_bits[$];

  // Two copies of the decoder state: one tracks what the block has accepted,
  // the other looks ahead while the stimulus is being built.
  dec_state_t decoder_state = '0;
  dec_state_t plan_state = '0;

  int   issued = 0;
  int   errors = 0;
  int   results_seen = 0;
  int   directed_words = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic results_pending = 1'b0;

  always #6 clk = ~clk;

  six_bit_text_code_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char         (out_char),
    .out_end_of_stream(out_end_of_stream),
    .out_last         (out_last)
  );

  // Character for a plain six-bit code; the case flag only moves the letters.
  function automatic logic [6:0] code_to_char(input logic [5:0] code, input logic lower);
    if (code == CODE_SPACE) return CHAR_SPACE;
    if (code <= 6'd7) return {1'b0, code} + 7'd8;
    if (code <= 6'd61) begin
      if (lower && code >= 6'd33 && code <= 6'd58) return {1'b0, code} + 7'd64;
      return {1'b0, code} + 7'd32;
    end
    if (code == CODE_TO_ESC) return CHAR_ESC;
    return CHAR_DEL;
  endfunction

  // Decodes one word on top of the given state. At most two characters come
  // out of a word; the end marker throws away whatever bits remain in it.
  function automatic dec_step_t decode_byte(input dec_state_t s, input logic [7:0] b);
    dec_step_t   r;
    logic [14:0] acc;
    logic [14:0] field;
    logic [7:0]  keep;
    logic [6:0]  code;
    logic        stop;
    int          cnt;
    int          need;
    r = '0;
    r.st = s;
    if (s.ended) return r;
    acc = (({8'd0, s.pbits} & ((15'd1 << s.pcount) - 15'd1)) << 8) | {7'd0, b};
    cnt = s.pcount + 8;
    stop = 1'b0;
    while (r.n < 2 && !stop) begin
      need = r.st.esc ? 7 : 6;
      if (cnt < need) begin
        stop = 1'b1;
      end else begin
        field = (acc >> (cnt - need)) & ((15'd1 << need) - 15'd1);
        code = field[6:0];
        cnt = cnt - need;
        if (r.st.esc) begin
          r.st.esc = 1'b0;
          if (code == LIT_END) begin
            r.ch[r.n] = 7'd0;
            r.eos[r.n] = 1'b1;
            r.n = r.n + 2'd1;
            r.st.ended = 1'b1;
            cnt = 0;
            stop = 1'b1;
          end else if (code == LIT_CASE_TOGGLE) begin
            r.st.lower = !r.st.lower;
          end else begin
            r.ch[r.n] = code;
            r.n = r.n + 2'd1;
          end
        end else if (code[5:0] == CODE_ESCAPE) begin
          r.st.esc = 1'b1;
        end else begin
          r.ch[r.n] = code_to_char(code[5:0], r.st.lower);
          r.n = r.n + 2'd1;
        end
      end
    end
    r.st.pcount = cnt[2:0];
    keep = (8'd1 << r.st.pcount) - 8'd1;
    r.st.pbits = acc[6:0] & keep[6:0];
    return r;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // Queues a word. Unless the end marker is wanted, a word that would end the
  // stream early is replaced by another random word.
  task automatic push_word(input logic [7:0] b, input logic allow_end);
    dec_step_t t;
    t = decode_byte(plan_state, b);
    while (t.st.ended && !plan_state.ended && !allow_end) begin
      b = 8'($urandom_range(0, 255));
      t = decode_byte(plan_state, b);
    end
    plan_state = t.st;
    byte_plan.push_back(b);
  endtask

  task automatic push_code(input logic [6:0] v, input int width);
    for (int i = width - 1; i >= 0; i--) code_bits.push_back(v[i]);
  endtask

  task automatic flush_words(input logic allow_end);
    logic [7:0] b;
    while (code_bits.size() >= 8) begin
      for (int i = 0; i < 8; i++) b = {b[6:0], code_bits.pop_front()};
      push_word(b, allow_end);
    end
  endtask

  // Zero padding only starts a partial plain code, so it cannot end the stream.
  task automatic pad_and_flush();
    while (code_bits.size() % 8 != 0) code_bits.push_back(1'b0);
    flush_words(1'b0);
  endtask

  // Sends random words until the decoder sits on a code boundary with no
  // escape open, so that the next code sequence is framed as it was built.
  task automatic realign_stream();
    while (plan_state.pcount != 3'd0 || plan_state.esc)
      push_word(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic add_random_code();
    int         pick;
    logic [6:0] lit;
    logic [5:0] code;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      push_code({1'b0, CODE_ESCAPE}, 6);
      push_code(LIT_CASE_TOGGLE, 7);
    end else if (pick < 20) begin
      lit = 7'($urandom_range(0, 127));
      while (lit == LIT_END || lit == LIT_CASE_TOGGLE) lit = 7'($urandom_range(0, 127));
      push_code({1'b0, CODE_ESCAPE}, 6);
      push_code(lit, 7);
    end else begin
      code = 6'($urandom_range(0, 63));
      while (code == CODE_ESCAPE) code = 6'($urandom_range(0, 63));
      push_code({1'b0, code}, 6);
    end
  endtask

  // Driver. A new word may be offered once the previous one is gone. At two
  // points the sender stops until the block has returned every character it
  // owes; it drops valid first so that the pending flag has caught up.
  always @(posedge clk) begin : driver
    logic drain_wait;
    logic sender_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'd0;
      issued <= 0;
    end else if (!in_valid || in_ready) begin
      drain_wait = (issued == directed_words || issued == MID_DRAIN) &&
                   (in_valid || results_pending);
      sender_gap = !(issued >= CALM_FIRST && issued < CALM_LAST) &&
                   ($urandom_range(0, 99) < 25);
      if (byte_plan.size() != 0 && !drain_wait && !sender_gap) begin
        in_valid <= 1'b1;
        in_data_byte <= byte_plan.pop_front();
        issued <= issued + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off: once enough words have gone out the receiver
  // refuses results until its hold-off counter runs out, so the record queue fills
  // and the block has to lower in_ready while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && issued >= HOLD_START) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor. Accepted words are decoded first, then any accepted result is
  // checked against the oldest character still owed, so the order of the two
  // handshakes within one edge never matters.
  always @(posedge clk) begin : monitor
    dec_step_t    s;
    char_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      results_pending <= 1'b0;
      decoder_state = '0;
    end else begin
      if (in_valid && in_ready) begin
        s = decode_byte(decoder_state, in_data_byte);
        decoder_state = s.st;
        for (int i = 0; i < s.n; i++) begin
          want.ch = s.ch[i];
          want.eos = s.eos[i];
          want.last = (i == s.n - 1);
          expected_chars.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_chars.size() == 0) begin
          flag_error($sformatf("result %0d came with none owed: char=%0d eos=%0b last=%0b",
                               results_seen, out_char, out_end_of_stream, out_last));
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch || out_end_of_stream !== want.eos ||
              out_last !== want.last)
            flag_error($sformatf(
              "result %0d: expected char=%0d eos=%0b last=%0b, got char=%0d eos=%0b last=%0b",
              results_seen, want.ch, want.eos, want.last,
              out_char, out_end_of_stream, out_last));
        end
      end
      results_pending <= (expected_chars.size() != 0);
      out_ready <= (hold_left == 0) &&
                   ((issued >= CALM_FIRST && issued < CALM_LAST) ||
                    $urandom_range(0, 99) >= 25);
    end
  end

  // Stimulus build, reset and end of run.
  initial begin : stimulus
    // Directed codes: the extremes of each mapping range, both fixed codes,
    // escaped literals zero and 127, and a case toggle around a run of
    // letters. After an escape the following entry is a seven-bit literal.
    int   directed_seq[$];
    logic after_escape;
    directed_seq = '{0, 1, 7, 8, 31, 33, 58, 61, 62, 63,
                     int'(CODE_ESCAPE), 0, int'(CODE_ESCAPE), 127,
                     int'(CODE_ESCAPE), int'(LIT_CASE_TOGGLE),
                     33, 45, 58, 59, 61, int'(CODE_ESCAPE), int'(LIT_CASE_TOGGLE), 63};
    after_escape = 1'b0;
    foreach (directed_seq[i]) begin
      push_code(7'(directed_seq[i]), after_escape ? 7 : 6);
      after_escape = !after_escape && (directed_seq[i] == int'(CODE_ESCAPE));
    end
    pad_and_flush();
    // Words with every bit low and every bit high.
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    directed_words = byte_plan.size();

    // Random part: mostly well-formed code runs, framed on a code boundary,
    // with bursts of raw random words in between.
    while (byte_plan.size() < TOTAL_WORDS) begin
      if ($urandom_range(0, 99) < 80) begin
        realign_stream();
        repeat ($urandom_range(4, 40)) add_random_code();
        pad_and_flush();
      end else begin
        repeat ($urandom_range(1, 6)) push_word(8'($urandom_range(0, 255)), 1'b0);
      end
    end

    // End of stream: two plain codes, an escape and the end literal, so that
    // the marker closes a word with seven bits still unread in it. Those bits
    // and the words after the marker must produce nothing.
    realign_stream();
    add_random_code();
    add_random_code();
    code_bits.delete();
    push_code(7'($urandom_range(0, 31)), 6);
    push_code(7'($urandom_range(33, 63)), 6);
    push_code({1'b0, CODE_ESCAPE}, 6);
    push_code(LIT_END, 7);
    push_code(7'($urandom_range(0, 127)), 7);
    flush_words(1'b1);
    repeat (6) push_word(8'($urandom_range(0, 255)), 1'b1);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Sampled on the falling edge, after every rising-edge update has settled.
    while (byte_plan.size() != 0 || in_valid || results_pending) @(negedge clk);
    repeat (20) @(negedge clk);
    if (expected_chars.size() != 0)
      flag_error($sformatf("%0d owed characters never came out", expected_chars.size()));
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run of this stimulus.
  initial begin
    #(12 * 200000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
